// ===== design/bbalc_pkg.sv =====
package bbalc_pkg;

   localparam int KIND_W   = 1;
   localparam int LEVEL_W  = 3;
   localparam int OFFSET_W = 7;
   localparam int INDEX_W  = 7;
   localparam int NEMPTY_W = 8;

   localparam logic [KIND_W-1:0] KIND_ALLOC = 1'b0;
   localparam logic [KIND_W-1:0] KIND_FREE  = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FIND,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_SPLIT,
      ST_FREE_RD,
      ST_FREE_CHK,
      ST_SET_RD,
      ST_SET_WR,
      ST_DONE
   } state_type;

endpackage

// ===== design/bbalc_ram.sv =====
module bbalc_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 255
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== design/buddy_block_allocator_core.sv =====
// allocate: find the lowest non-empty level at or above the request, scan it from index 0 for
//   the first free block, then split it down to the requested level; fails with no free block or a bad level
// free: merge with each free buddy on the way up to the top level, then mark the merged block free
// one item at a time, busy is high through the result strobe, next transfer in the cycle after it
// synchronous reset starts a clearing pass over all 2^LEVELS-1 bits of the free map,
//   busy is high throughout and only the top-level block is free afterwards; no stall
module buddy_block_allocator_core #(
   parameter int LEVELS = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [bbalc_pkg::KIND_W-1:0]     req_kind,
   input  logic [bbalc_pkg::LEVEL_W-1:0]    req_level,
   input  logic [bbalc_pkg::OFFSET_W-1:0]   req_offset,
   output logic                             rsp_valid,
   output logic                             rsp_success,
   output logic [bbalc_pkg::INDEX_W-1:0]    rsp_block_index,
   output logic [bbalc_pkg::NEMPTY_W-1:0]   rsp_nonempty_levels
);

   import bbalc_pkg::*;

   localparam int MAP_SIZE = (1 << LEVELS) - 1;
   localparam int AW       = LEVELS;
   localparam int IW       = LEVELS - 1;
   localparam int LVW      = (LEVELS > 2) ? $clog2(LEVELS) : 1;
   localparam int CW       = LEVELS;

   localparam logic [AW-1:0]  LAST_ADDR = AW'(MAP_SIZE - 1);
   localparam logic [LVW-1:0] TOP_LEVEL = LVW'(LEVELS - 1);

   function automatic logic [AW-1:0] base_of(input logic [LVW-1:0] lv);
      base_of = AW'((1 << LEVELS) - (1 << (LEVELS - int'(lv))));
   endfunction

   function automatic logic [IW-1:0] mask_of(input logic [LVW-1:0] lv);
      mask_of = IW'((1 << (LEVELS - 1 - int'(lv))) - 1);
   endfunction

   state_type        state_ff, state_in;
   logic [LVW-1:0]   lv_ff, lv_in;
   logic [LVW-1:0]   need_ff, need_in;
   logic [IW-1:0]    idx_ff, idx_in;
   logic [KIND_W-1:0] kind_ff, kind_in;
   logic             ok_ff, ok_in;
   logic [AW-1:0]    clr_ff, clr_in;
   logic [CW-1:0]    cnt_ff [LEVELS];
   logic [CW-1:0]    cnt_in [LEVELS];

   logic             ram_we;
   logic [AW-1:0]    ram_waddr;
   logic             ram_wdata;
   logic [AW-1:0]    ram_raddr;
   logic             ram_rdata;

   logic [AW-1:0]    cur_addr;
   logic [AW-1:0]    buddy_addr;
   logic             found;
   logic [LVW-1:0]   found_lv;
   logic [LVW-1:0]   req_lv;
   logic             req_lv_ok;

   bbalc_ram #(
      .WIDTH(1),
      .DEPTH(MAP_SIZE)
   ) u_map (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   assign cur_addr   = base_of(lv_ff) + AW'(idx_ff);
   assign buddy_addr = base_of(lv_ff) + AW'(idx_ff ^ IW'(1));
   assign req_lv     = LVW'(req_level);
   assign req_lv_ok  = int'(req_level) < LEVELS;

   // lowest level at or above the request that holds a free block
   always_comb begin
      found    = 1'b0;
      found_lv = '0;
      for (int l = LEVELS - 1; l >= 0; l--) begin
         if (l >= int'(need_ff) && cnt_ff[l] != '0) begin
            found    = 1'b1;
            found_lv = LVW'(l);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         for (int l = 0; l < LEVELS; l++) begin
            cnt_ff[l] <= (l == LEVELS - 1) ? CW'(1) : '0;
         end
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         cnt_ff   <= cnt_in;
      end
      lv_ff   <= lv_in;
      need_ff <= need_in;
      idx_ff  <= idx_in;
      kind_ff <= kind_in;
      ok_ff   <= ok_in;
   end

   always_comb begin
      state_in  = state_ff;
      lv_in     = lv_ff;
      need_in   = need_ff;
      idx_in    = idx_ff;
      kind_in   = kind_ff;
      ok_in     = ok_ff;
      clr_in    = clr_ff;
      cnt_in    = cnt_ff;
      ram_we    = 1'b0;
      ram_waddr = cur_addr;
      ram_wdata = 1'b0;
      ram_raddr = cur_addr;

      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = (clr_ff == LAST_ADDR);
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               kind_in = req_kind;
               lv_in   = req_lv;
               need_in = req_lv;
               idx_in  = IW'(req_offset) & mask_of(req_lv);
               ok_in   = 1'b0;
               if (!req_lv_ok) begin
                  state_in = ST_DONE;
               end else if (req_kind == KIND_ALLOC) begin
                  state_in = ST_FIND;
               end else begin
                  state_in = ST_FREE_RD;
               end
            end
         end
         ST_FIND: begin
            if (found) begin
               lv_in    = found_lv;
               idx_in   = '0;
               state_in = ST_SCAN_RD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SCAN_RD: begin
            state_in = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            if (ram_rdata) begin
               ram_we        = 1'b1;
               cnt_in[lv_ff] = cnt_ff[lv_ff] - CW'(1);
               state_in      = ST_SPLIT;
            end else begin
               idx_in   = idx_ff + IW'(1);
               state_in = ST_SCAN_RD;
            end
         end
         ST_SPLIT: begin
            if (lv_ff == need_ff) begin
               ok_in    = 1'b1;
               state_in = ST_DONE;
            end else begin
               // right half of the lower level goes free
               lv_in    = lv_ff - LVW'(1);
               idx_in   = (idx_ff << 1) | IW'(1);
               state_in = ST_SET_RD;
            end
         end
         ST_FREE_RD: begin
            if (lv_ff == TOP_LEVEL) begin
               state_in = ST_SET_RD;
            end else begin
               ram_raddr = buddy_addr;
               state_in  = ST_FREE_CHK;
            end
         end
         ST_FREE_CHK: begin
            ram_raddr = buddy_addr;
            if (ram_rdata) begin
               ram_we        = 1'b1;
               ram_waddr     = buddy_addr;
               cnt_in[lv_ff] = cnt_ff[lv_ff] - CW'(1);
               idx_in        = idx_ff >> 1;
               lv_in         = lv_ff + LVW'(1);
               state_in      = ST_FREE_RD;
            end else begin
               state_in = ST_SET_RD;
            end
         end
         ST_SET_RD: begin
            state_in = ST_SET_WR;
         end
         ST_SET_WR: begin
            ram_we    = 1'b1;
            ram_wdata = 1'b1;
            // count only a bit that was clear, a repeated free leaves it as is
            if (!ram_rdata) begin
               cnt_in[lv_ff] = cnt_ff[lv_ff] + CW'(1);
            end
            if (kind_ff == KIND_FREE) begin
               ok_in    = 1'b1;
               state_in = ST_DONE;
            end else begin
               idx_in   = idx_ff & ~IW'(1);
               state_in = ST_SPLIT;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = (state_ff == ST_DONE);
   assign rsp_success     = ok_ff;
   assign rsp_block_index = (ok_ff && kind_ff == KIND_ALLOC) ? INDEX_W'(idx_ff) : '0;

   for (genvar l = 0; l < NEMPTY_W; l++) begin : g_nempty
      if (l < LEVELS) begin : g_lvl
         assign rsp_nonempty_levels[l] = (cnt_ff[l] != '0);
      end else begin : g_none
         assign rsp_nonempty_levels[l] = 1'b0;
      end
   end

endmodule

// ===== design/bbalc_checker.sv =====
module bbalc_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             start,
   input logic                             busy,
   input logic                             rsp_valid,
   input logic                             rsp_success,
   input logic [bbalc_pkg::INDEX_W-1:0]    rsp_block_index
);

   // clearing pass keeps the block busy right after reset
   a_busy_after_reset: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> busy)
      else $error("not busy after reset");

   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transfer did not raise busy");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_idle_after_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy ##1 !busy)
      else $error("block not ready after result");

   a_fail_index_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_success) |-> (rsp_block_index == '0))
      else $error("nonzero index on failed result");

endmodule

bind buddy_block_allocator_core bbalc_checker u_bbalc_checker (.*);

// ===== test/buddy_block_allocator_core_tb.sv =====
module buddy_block_allocator_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bbalc_pkg::*;

   localparam int LEVELS       = 8;
   localparam int MAP_N        = (1 << LEVELS) - 1;
   localparam int CYCLE_LIMIT  = 1_500_000;
   localparam int SETTLE_WAIT  = 600;

   typedef struct packed {
      logic                success;
      logic [INDEX_W-1:0]  block_index;
      logic [NEMPTY_W-1:0] nonempty_levels;
   } outcome_type;

   typedef struct {
      int level;
      int index;
   } held_block_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [KIND_W-1:0]   req_kind = KIND_ALLOC;
   logic [LEVEL_W-1:0]  req_level = '0;
   logic [OFFSET_W-1:0] req_offset = '0;
   logic                rsp_valid;
   logic                rsp_success;
   logic [INDEX_W-1:0]  rsp_block_index;
   logic [NEMPTY_W-1:0] rsp_nonempty_levels;

   bit             free_map [MAP_N];
   outcome_type    pending_outcomes [$];
   held_block_type held_blocks [$];
   int             fail_count = 0;
   int             cycle_count = 0;
   bit             pauses_on = 1'b0;

   buddy_block_allocator_core #(.LEVELS(LEVELS)) dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_kind            (req_kind),
      .req_level           (req_level),
      .req_offset          (req_offset),
      .rsp_valid           (rsp_valid),
      .rsp_success         (rsp_success),
      .rsp_block_index     (rsp_block_index),
      .rsp_nonempty_levels (rsp_nonempty_levels)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[buddy_block_allocator_core] ERROR");
         $finish;
      end
   end

   // ---------------- free map predictor ----------------

   function automatic int level_first(int lv);
      return (1 << LEVELS) - (1 << (LEVELS - lv));
   endfunction

   function automatic int level_size(int lv);
      return 1 << (LEVELS - 1 - lv);
   endfunction

   function automatic logic [NEMPTY_W-1:0] free_level_mask();
      logic [NEMPTY_W-1:0] mask;
      mask = '0;
      for (int lv = 0; lv < LEVELS && lv < NEMPTY_W; lv++)
         for (int i = 0; i < level_size(lv); i++)
            if (free_map[level_first(lv) + i]) mask[lv] = 1'b1;
      return mask;
   endfunction

   // lowest non-empty level at or above need, lowest index there, split down
   function automatic bit take_block(int need, output int idx);
      int lv;
      idx = 0;
      for (int l = need; l < LEVELS; l++)
         for (int i = 0; i < level_size(l); i++)
            if (free_map[level_first(l) + i]) begin
               free_map[level_first(l) + i] = 1'b0;
               idx = i;
               lv = l;
               while (lv > need) begin
                  lv--;
                  idx = idx << 1;
                  free_map[level_first(lv) + idx + 1] = 1'b1;
               end
               return 1'b1;
            end
      return 1'b0;
   endfunction

   function automatic void return_block(int lv, int idx);
      int buddy;
      idx = idx & (level_size(lv) - 1);
      while (lv < LEVELS - 1) begin
         buddy = level_first(lv) + (idx ^ 1);
         if (!free_map[buddy]) break;
         free_map[buddy] = 1'b0;
         idx = idx >> 1;
         lv++;
      end
      free_map[level_first(lv) + idx] = 1'b1;
   endfunction

   function automatic outcome_type predict_outcome(logic [KIND_W-1:0] kind,
                                                   logic [LEVEL_W-1:0] level,
                                                   logic [OFFSET_W-1:0] offset);
      outcome_type o;
      int          idx;
      o = '0;
      if (int'(level) < LEVELS) begin
         if (kind == KIND_ALLOC) begin
            if (take_block(int'(level), idx)) begin
               o.success     = 1'b1;
               o.block_index = idx[INDEX_W-1:0];
            end
         end else begin
            return_block(int'(level), int'(offset));
            o.success = 1'b1;
         end
      end
      o.nonempty_levels = free_level_mask();
      return o;
   endfunction

   // ---------------- result checker ----------------

   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid) begin
         if (pending_outcomes.size() == 0) begin
            $error("result with no transfer outstanding: success %0d index %0d levels %02h",
                   rsp_success, rsp_block_index, rsp_nonempty_levels);
            fail_count++;
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_success !== want.success) begin
               $error("success: expected %0d, got %0d", want.success, rsp_success);
               fail_count++;
            end
            if (rsp_block_index !== want.block_index) begin
               $error("block_index: expected %0d, got %0d", want.block_index, rsp_block_index);
               fail_count++;
            end
            if (rsp_nonempty_levels !== want.nonempty_levels) begin
               $error("nonempty_levels: expected %02h, got %02h",
                      want.nonempty_levels, rsp_nonempty_levels);
               fail_count++;
            end
         end
      end
   end

   // ---------------- request side ----------------

   // called and returns at a falling edge
   task automatic send_request(input logic [KIND_W-1:0] kind, input logic [LEVEL_W-1:0] level,
                               input logic [OFFSET_W-1:0] offset, output outcome_type predicted);
      start      = 1'b1;
      req_kind   = kind;
      req_level  = level;
      req_offset = offset;
      do @(posedge clock); while (busy);
      predicted = predict_outcome(kind, level, offset);
      pending_outcomes.push_back(predicted);
      @(negedge clock);
      start = 1'b0;
   endtask

   task automatic allocate_level(input int lv);
      outcome_type    o;
      held_block_type b;
      send_request(KIND_ALLOC, LEVEL_W'(lv), OFFSET_W'($urandom_range(0, 127)), o);
      if (o.success) begin
         b.level = lv;
         b.index = int'(o.block_index);
         held_blocks.push_back(b);
      end
   endtask

   task automatic free_at(input int lv, input int offset);
      outcome_type o;
      send_request(KIND_FREE, LEVEL_W'(lv), OFFSET_W'(offset), o);
   endtask

   task automatic maybe_pause();
      if (pauses_on && $urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 19)) @(negedge clock);
   endtask

   // ---------------- tests ----------------

   task automatic test_split_and_merge();
      allocate_level(0);
      allocate_level(0);
      allocate_level(3);
      free_at(0, 0);
      free_at(0, 1);
      // last free merges all the way back to the whole pool
      free_at(3, 1);
   endtask

   task automatic test_exhaustion();
      allocate_level(7);
      allocate_level(0);
      allocate_level(7);
      // index bits above the level's block count are dropped
      free_at(7, 127);
      allocate_level(6);
      allocate_level(6);
      allocate_level(6);
      free_at(6, 127);
      free_at(6, 0);
   endtask

   task automatic test_free_oddities();
      // double free of the whole pool
      free_at(7, 0);
      // overlapping frees inside an already free pool
      free_at(0, 127);
      free_at(0, 126);
      allocate_level(1);
      allocate_level(7);
      free_at(7, 0);
      held_blocks.delete();
   endtask

   task automatic test_random_churn(input int n_items);
      int             r;
      int             k;
      int             offset;
      held_block_type b;
      for (int n = 0; n < n_items; n++) begin
         maybe_pause();
         r = $urandom_range(0, 99);
         if (r < 5) begin
            if ($urandom_range(0, 1)) allocate_level($urandom_range(0, 7));
            else free_at($urandom_range(0, 7), $urandom_range(0, 127));
         end else if (held_blocks.size() > 0 && r < 50) begin
            k = $urandom_range(0, held_blocks.size() - 1);
            b = held_blocks[k];
            held_blocks.delete(k);
            offset = b.index;
            if ($urandom_range(0, 3) == 0)
               offset = ($urandom_range(0, 127) & ~(level_size(b.level) - 1)) | b.index;
            free_at(b.level, offset);
         end else if ($urandom_range(0, 99) < 70) begin
            allocate_level($urandom_range(0, 3));
         end else begin
            allocate_level($urandom_range(0, 7));
         end
      end
   endtask

   task automatic test_drain_held();
      int             k;
      held_block_type b;
      // hold off until every outstanding result is back
      wait (pending_outcomes.size() == 0);
      @(negedge clock);
      while (held_blocks.size() > 0) begin
         maybe_pause();
         k = $urandom_range(0, held_blocks.size() - 1);
         b = held_blocks[k];
         held_blocks.delete(k);
         free_at(b.level, b.index);
      end
   endtask

   initial begin
      free_map = '{default: 1'b0};
      free_map[level_first(LEVELS - 1)] = 1'b1;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      test_split_and_merge();
      test_exhaustion();
      test_free_oddities();
      pauses_on = 1'b1;
      test_random_churn(220);
      test_drain_held();
      test_random_churn(150);
      pauses_on = 1'b0;
      test_random_churn(80);
      test_drain_held();

      wait (pending_outcomes.size() == 0);
      repeat (SETTLE_WAIT) @(posedge clock);
      if (fail_count == 0) begin
         $display("[buddy_block_allocator_core] OK");
      end else begin
         $display("[buddy_block_allocator_core] ERROR");
      end
      $finish;
   end

endmodule
